// ===== rtl/lph_pkg.sv =====
// Shared types and constants for the linear probing hash table.
package lph_pkg;

    localparam int TABLE_SLOTS_DEF = 256;

    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int WORD_W = 1 + KEY_W + VAL_W;

    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_GET = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

    localparam logic [VAL_W-1:0] VAL_MISS = {VAL_W{1'b1}};

    typedef struct packed {
        logic load;
        logic issue;
        logic advance;
        logic finish;
        logic clear_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic home_ready;
        logic hit;
        logic sweep_end;
        logic idx_last;
    } dp_stat_t;

endpackage

// ===== rtl/lph_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lph_datapath.sv =====
// Datapath of the hash table: item registers, home slot unit, probe pointer and slot RAM.
module lph_datapath #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lph_pkg::dp_cmd_t                cmd,
    output lph_pkg::dp_stat_t               stat,
    input  logic                            mode,
    input  logic [lph_pkg::KEY_W-1:0]       key,
    input  logic signed [lph_pkg::VAL_W-1:0] value,
    output logic [lph_pkg::STAT_W-1:0]      status,
    output logic signed [lph_pkg::VAL_W-1:0] read_value
);
    import lph_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_SLOTS);
    localparam int REM_W = ADDR_W + 1;
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W = KEY_W + RECIP_W;
    localparam int RECIP_SH = KEY_W + ADDR_W;
    localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_SLOTS - 1);
    localparam logic [REM_W-1:0] SLOTS_EXT = REM_W'(TABLE_SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(TABLE_SLOTS));
    localparam logic [1:0] MOD_STEPS = 2'd2;

    logic              mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] count_reg;
    logic              mod_busy_reg;
    logic [1:0]        mod_cnt_reg;
    logic [REM_W-1:0]  quot_lo_reg;
    logic [REM_W-1:0]  diff_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [VAL_W-1:0]  res_value_reg;
    logic [STAT_W-1:0] status_reg;
    logic [VAL_W-1:0]  read_value_reg;

    logic [ADDR_W-1:0] idx_inc;
    logic [PROD_W-1:0] recip_prod;
    logic [PROD_W-1:0] quot_full;
    logic [ADDR_W-1:0] reduced;
    logic              hit;
    logic              q_used;
    logic [KEY_W-1:0]  q_key;
    logic [VAL_W-1:0]  q_val;
    logic [WORD_W-1:0] ram_q;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Home slot for a size that is not a power of two: a reciprocal multiply gives a
    // quotient that is low by at most one, so one compare and subtract finishes it.
    assign recip_prod = PROD_W'(key_reg) * PROD_W'(RECIP);
    assign quot_full  = recip_prod >> RECIP_SH;
    assign reduced    = (diff_reg >= SLOTS_EXT) ? ADDR_W'(diff_reg - SLOTS_EXT)
                                                : ADDR_W'(diff_reg);
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign q_used = ram_q[WORD_W-1];
    assign q_key  = ram_q[VAL_W +: KEY_W];
    assign q_val  = ram_q[VAL_W-1:0];
    assign hit    = !q_used || (q_key == key_reg);

    assign wr_en   = cmd.clear_step || (cmd.finish && hit && (mode_reg == MODE_SET));
    assign wr_data = cmd.clear_step ? '0 : {1'b1, key_reg, value_reg};
    assign rd_en   = cmd.issue || cmd.advance;
    assign rd_addr = cmd.issue ? idx_reg : idx_inc;

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clear_step || cmd.advance)
        begin
            idx_next = idx_inc;
        end
        else if (cmd.load)
        begin
            idx_next = IS_POW2 ? key[ADDR_W-1:0] : '0;
        end
        else if (mod_busy_reg && (mod_cnt_reg == '0))
        begin
            idx_next = reduced;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            mod_busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.load)
            begin
                mod_busy_reg <= !IS_POW2;
            end
            else if (mod_busy_reg && (mod_cnt_reg == '0))
            begin
                mod_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_lo_reg <= quot_full[REM_W-1:0];
        diff_reg    <= key_reg[REM_W-1:0] - REM_W'(quot_lo_reg * SLOTS_EXT);
        if (cmd.load)
        begin
            mode_reg    <= mode;
            key_reg     <= key;
            value_reg   <= value;
            mod_cnt_reg <= MOD_STEPS;
        end
        else if (mod_busy_reg)
        begin
            mod_cnt_reg <= mod_cnt_reg - 1'b1;
        end
        if (cmd.issue)
        begin
            count_reg <= '0;
        end
        else if (cmd.advance)
        begin
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            if (!hit)
            begin
                res_status_reg <= STATUS_FULL;
                res_value_reg  <= '0;
            end
            else if (mode_reg == MODE_SET)
            begin
                res_status_reg <= STATUS_OK;
                res_value_reg  <= '0;
            end
            else if (q_used)
            begin
                res_status_reg <= STATUS_OK;
                res_value_reg  <= q_val;
            end
            else
            begin
                res_status_reg <= STATUS_MISS;
                res_value_reg  <= VAL_MISS;
            end
        end
        if (cmd.out_load)
        begin
            status_reg     <= res_status_reg;
            read_value_reg <= res_value_reg;
        end
    end

    lph_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    assign stat.home_ready = !mod_busy_reg;
    assign stat.hit        = hit;
    assign stat.sweep_end  = (count_reg == LAST_IDX);
    assign stat.idx_last   = (idx_reg == LAST_IDX);

    assign status     = status_reg;
    assign read_value = read_value_reg;

`ifndef ASSERT_OFF
    a_no_write_while_probing: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && cmd.advance))
        else $error("slot write during a probe step");

    a_load_idle_mod: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !mod_busy_reg)
        else $error("probe issued before the home slot is ready");

    a_load_when_home_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !mod_busy_reg)
        else $error("word loaded while the home slot unit is busy");
`endif

endmodule

// ===== rtl/lph_ctrl.sv =====
// Controller of the hash table: clearing pass, probe sequencing and output word register.
module lph_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lph_pkg::dp_cmd_t  cmd,
    input  lph_pkg::dp_stat_t stat
);
    import lph_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_PROBE,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (stat.home_ready)
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stat.hit || stat.sweep_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_ISSUE))
        else $error("accepted word did not start a probe");

    a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result not presented after transfer");

    a_finish_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.finish && cmd.advance))
        else $error("probe both finished and advanced");
`endif

endmodule

// ===== rtl/linear_probe_hash_table_core.sv =====
// Top level of the linear probing hash table.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   mode, key, value
//   out      output     out_valid / out_ready status, read_value
//
// An item passes through load, issue, P probe steps and the result transfer, where P is
// the number of slots probed (one RAM read per cycle, 1 to TABLE_SLOTS); a table size
// that is not a power of two adds a wait for the home slot remainder.
// After reset a clearing pass writes every slot, one per cycle, before the first word
// is accepted.
// A finished result waits in the output register while the next word is taken in;
// a result stalls in the controller only when the output register is still full.
module linear_probe_hash_table_core #(
    parameter int TABLE_SLOTS = lph_pkg::TABLE_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [lph_pkg::KEY_W-1:0]        key,
    input  logic signed [lph_pkg::VAL_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lph_pkg::STAT_W-1:0]       status,
    output logic signed [lph_pkg::VAL_W-1:0] read_value
);
    import lph_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lph_datapath #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (mode),
        .key        (key),
        .value      (value),
        .status     (status),
        .read_value (read_value)
    );

endmodule
